>>> src/six_axis_button_event_decoder_assert.svh
// assertion macros for the six-axis event decoder
`ifndef SIX_AXIS_BUTTON_EVENT_DECODER_ASSERT_SVH
`define SIX_AXIS_BUTTON_EVENT_DECODER_ASSERT_SVH

// property that holds at every clock edge outside reset
`define SAB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sabed_pkg.sv
// shared types and constants for the six-axis event decoder
package sabed_pkg;

   localparam logic [31:0] RESET_MASK = 32'd55;

   localparam logic [1:0] MODE_AXIS   = 2'd0;
   localparam logic [1:0] MODE_BUTTON = 2'd1;

   localparam logic [1:0] KIND_MOTION  = 2'd0;
   localparam logic [1:0] KIND_PRESS   = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   localparam logic [3:0] ID_NONE  = 4'd0;
   localparam logic [3:0] ID_SHIFT = 4'd11;
   localparam logic [3:0] ID_CTRL  = 4'd12;
   localparam logic [3:0] ID_ALT   = 4'd13;

   localparam int QUEUE_DEPTH = 2;

   // word handed from the front part to the back part
   typedef struct packed {
      logic        is_axis;
      logic [15:0] trans_x;
      logic [15:0] trans_y;
      logic [15:0] trans_z;
      logic [15:0] rot_x;
      logic [15:0] rot_y;
      logic [15:0] rot_z;
      logic [1:0]  kind;
      logic [3:0]  button_id;
      logic [2:0]  modifier_set;
   } task_type;

   function automatic logic [3:0] button_lookup(input logic [31:0] changed);
      logic [3:0] id;
      id = ID_NONE;
      case (changed)
         32'd4:        id = 4'd1;
         32'd16:       id = 4'd2;
         32'd32:       id = 4'd3;
         32'd256:      id = 4'd4;
         32'd67108864: id = 4'd5;
         32'd4096:     id = 4'd6;
         32'd8192:     id = 4'd7;
         32'd16384:    id = 4'd8;
         32'd32768:    id = 4'd9;
         32'd4194304:  id = 4'd10;
         32'd16777216: id = ID_SHIFT;
         32'd33554432: id = ID_CTRL;
         32'd8388608:  id = ID_ALT;
         32'd1:        id = 4'd14;
         32'd2:        id = 4'd15;
         default:      id = ID_NONE;
      endcase
      return id;
   endfunction

   function automatic logic [16:0] mag16(input logic [15:0] raw);
      return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
   endfunction

endpackage

>>> src/sabed_front.sv
// front part: accepts words, decodes buttons, keeps button and modifier state
module sabed_front
   import sabed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_trans_x,
   input  logic [15:0] req_trans_y,
   input  logic [15:0] req_trans_z,
   input  logic [15:0] req_rot_x,
   input  logic [15:0] req_rot_y,
   input  logic [15:0] req_rot_z,
   input  logic [31:0] req_button_word,
   input  logic        q_full,
   output logic        q_push,
   output task_type    q_word
);

   logic [31:0] mask_ff, last_ff;
   logic [2:0]  mods_ff, mods_in;
   logic [31:0] masked, changed;
   logic        pressed;
   logic [3:0]  id;
   logic [2:0]  modbit;

   assign req_ready = !q_full;
   assign masked    = req_button_word & mask_ff;
   assign changed   = last_ff ^ masked;
   assign pressed   = (changed & masked) != 32'd0;
   assign id        = button_lookup(changed);

   always_comb begin
      case (id)
         ID_SHIFT: modbit = 3'b001;
         ID_CTRL:  modbit = 3'b010;
         ID_ALT:   modbit = 3'b100;
         default:  modbit = 3'b000;
      endcase
      mods_in = pressed ? (mods_ff | modbit) : (mods_ff & ~modbit);
   end

   assign q_push = req_valid && req_ready
                   && (req_mode == MODE_AXIS || req_mode == MODE_BUTTON);

   always_comb begin
      q_word.is_axis      = (req_mode == MODE_AXIS);
      q_word.trans_x      = q_word.is_axis ? req_trans_x : 16'd0;
      q_word.trans_y      = q_word.is_axis ? req_trans_y : 16'd0;
      q_word.trans_z      = q_word.is_axis ? req_trans_z : 16'd0;
      q_word.rot_x        = req_rot_x;
      q_word.rot_y        = req_rot_y;
      q_word.rot_z        = req_rot_z;
      q_word.kind         = q_word.is_axis ? KIND_MOTION : (pressed ? KIND_PRESS : KIND_RELEASE);
      q_word.button_id    = q_word.is_axis ? ID_NONE : id;
      q_word.modifier_set = q_word.is_axis ? mods_ff : mods_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= RESET_MASK;
         last_ff <= 32'd0;
         mods_ff <= 3'd0;
      end else begin
         if (csr_write_enable) mask_ff <= csr_write_data;
         if (q_push && req_mode == MODE_BUTTON) begin
            last_ff <= masked;
            mods_ff <= mods_in;
         end
      end
   end

endmodule

>>> src/sabed_queue.sv
// small fifo between front and back parts
module sabed_queue
   import sabed_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_word,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output task_type pop_word
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   task_type         mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_word  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

endmodule

>>> src/sabed_back.sv
// back part: iterative square root and divisions for axis words
module sabed_back
   import sabed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_not_empty,
   input  task_type    q_word,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_trans_x,
   output logic [15:0] rsp_out_trans_y,
   output logic [15:0] rsp_out_trans_z,
   output logic [23:0] rsp_angle,
   output logic [15:0] rsp_unit_x,
   output logic [15:0] rsp_unit_y,
   output logic [15:0] rsp_unit_z,
   output logic [3:0]  rsp_button_id,
   output logic [2:0]  rsp_modifier_set
);

   `include "six_axis_button_event_decoder_assert.svh"

   typedef enum logic [2:0] {IDLE, SQUARE, ROOT, DIVIDE, OUTPUT} state_type;

   state_type   state_ff;
   task_type    w_ff;
   logic [1:0]  step_ff;
   logic [4:0]  cnt_ff;
   logic [33:0] sum_ff;
   logic [51:0] rad_ff;
   logic [25:0] rem_ff, root_ff;
   logic [1:0]  comp_ff;
   logic [39:0] num_ff;
   logic [24:0] drem_ff;
   logic [5:0]  dcnt_ff;
   logic [15:0] ux_ff, uy_ff, uz_ff;

   logic [16:0] mag;
   logic [33:0] sq;
   logic [28:0] trial;
   logic [27:0] rem_shift;
   logic [15:0] comp_raw;
   logic [25:0] dtrial;
   logic [15:0] sat;
   logic [39:0] qnext;

   always_comb begin
      case (step_ff)
         2'd0:    comp_raw = w_ff.rot_x;
         2'd1:    comp_raw = w_ff.rot_y;
         default: comp_raw = w_ff.rot_z;
      endcase
      case (comp_ff)
         2'd0:    comp_raw = (state_ff == DIVIDE) ? w_ff.rot_x : comp_raw;
         2'd1:    comp_raw = (state_ff == DIVIDE) ? w_ff.rot_y : comp_raw;
         default: comp_raw = (state_ff == DIVIDE) ? w_ff.rot_z : comp_raw;
      endcase
   end

   assign mag       = mag16(comp_raw);
   assign sq        = mag * mag;
   // restoring root, two radicand bits per step
   assign rem_shift = {rem_ff, rad_ff[51:50]};
   assign trial     = {1'b0, rem_shift} - {1'b0, root_ff, 2'b01};
   // restoring divide, one quotient bit per step
   assign dtrial    = {drem_ff, num_ff[39]} - {2'b00, root_ff[23:0]};
   assign qnext     = {num_ff[38:0], !dtrial[25]};

   always_comb begin
      if (comp_raw[15])
         sat = (qnext[39:15] != 25'd0) ? 16'h8000 : 16'd0 - qnext[15:0];
      else
         sat = (qnext[39:15] != 25'd0 || qnext[14:0] == 15'h7fff) ? 16'h7fff : qnext[15:0];
   end

   assign q_pop = (state_ff == IDLE) && q_not_empty && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         rsp_valid <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (q_pop) begin
                  w_ff    <= q_word;
                  step_ff <= 2'd0;
                  sum_ff  <= '0;
                  state_ff <= q_word.is_axis ? SQUARE : OUTPUT;
               end
            end
            SQUARE: begin
               sum_ff <= sum_ff + sq;
               if (step_ff == 2'd2) begin
                  state_ff <= ROOT;
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  root_ff  <= '0;
               end
               step_ff <= step_ff + 2'd1;
               rad_ff  <= {2'b00, sum_ff + sq, 16'd0};
            end
            ROOT: begin
               if (!trial[28]) begin
                  rem_ff  <= trial[25:0];
                  root_ff <= {root_ff[24:0], 1'b1};
               end else begin
                  rem_ff  <= rem_shift[25:0];
                  root_ff <= {root_ff[24:0], 1'b0};
               end
               rad_ff <= {rad_ff[49:0], 2'b00};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd25) begin
                  comp_ff  <= 2'd0;
                  state_ff <= DIVIDE;
                  dcnt_ff  <= '0;
                  drem_ff  <= '0;
                  num_ff   <= {mag16(w_ff.rot_x), 23'd0};
               end
            end
            DIVIDE: begin
               if (root_ff[23:0] == 24'd0) begin
                  ux_ff <= 16'd0;
                  uy_ff <= 16'd0;
                  uz_ff <= 16'h7fff;
                  state_ff <= OUTPUT;
               end else if (dcnt_ff == 6'd39) begin
                  case (comp_ff)
                     2'd0:    ux_ff <= sat;
                     2'd1:    uy_ff <= sat;
                     default: uz_ff <= sat;
                  endcase
                  dcnt_ff <= '0;
                  drem_ff <= '0;
                  comp_ff <= comp_ff + 2'd1;
                  if (comp_ff == 2'd0) num_ff <= {mag16(w_ff.rot_y), 23'd0};
                  else num_ff <= {mag16(w_ff.rot_z), 23'd0};
                  if (comp_ff == 2'd2) state_ff <= OUTPUT;
               end else begin
                  drem_ff <= dtrial[25] ? {drem_ff[23:0], num_ff[39]} : dtrial[24:0];
                  num_ff  <= qnext;
                  dcnt_ff <= dcnt_ff + 6'd1;
               end
            end
            OUTPUT: begin
               rsp_valid        <= 1'b1;
               rsp_kind         <= w_ff.kind;
               rsp_out_trans_x  <= w_ff.trans_x;
               rsp_out_trans_y  <= w_ff.trans_y;
               rsp_out_trans_z  <= w_ff.trans_z;
               rsp_angle        <= w_ff.is_axis ? root_ff[23:0] : 24'd0;
               rsp_unit_x       <= w_ff.is_axis ? ux_ff : 16'd0;
               rsp_unit_y       <= w_ff.is_axis ? uy_ff : 16'd0;
               rsp_unit_z       <= w_ff.is_axis ? uz_ff : 16'd0;
               rsp_button_id    <= w_ff.button_id;
               rsp_modifier_set <= w_ff.modifier_set;
               state_ff         <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      end
   end

   `SAB_ASSERT(a_pop_idle, clock, reset, !(q_pop && state_ff != IDLE), "pop outside idle")
   `SAB_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == OUTPUT, rsp_valid, "result not shown")
   `SAB_ASSERT(a_kind_ok, clock, reset, !(rsp_valid && rsp_kind == 2'd3), "bad kind")

endmodule

>>> src/six_axis_button_event_decoder.sv
// top level of the six-axis event decoder
//  channel | ports   | handshake
//  input   | req_*   | req_valid / req_ready
//  result  | rsp_*   | rsp_valid / rsp_ready
//  config  | csr_*   | csr_write_enable, no wait
// an axis word runs the SQUARE, ROOT and DIVIDE states in the back part, with one
// division per rotation component; a zero rotation skips the divisions.
// a button word goes from IDLE straight to OUTPUT; ignored modes give none.
// the back part takes the next word only once the waiting result has gone.
// reset is synchronous, active high; a two-word queue lets the front keep
// accepting while the back works or the result waits.
module six_axis_button_event_decoder
   import sabed_pkg::*;
#(
   parameter int QDEPTH = QUEUE_DEPTH
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_trans_x,
   input  logic [15:0] req_trans_y,
   input  logic [15:0] req_trans_z,
   input  logic [15:0] req_rot_x,
   input  logic [15:0] req_rot_y,
   input  logic [15:0] req_rot_z,
   input  logic [31:0] req_button_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_trans_x,
   output logic [15:0] rsp_out_trans_y,
   output logic [15:0] rsp_out_trans_z,
   output logic [23:0] rsp_angle,
   output logic [15:0] rsp_unit_x,
   output logic [15:0] rsp_unit_y,
   output logic [15:0] rsp_unit_z,
   output logic [3:0]  rsp_button_id,
   output logic [2:0]  rsp_modifier_set
);

   logic     q_full, q_push, q_pop, q_not_empty;
   task_type q_in, q_out;

   sabed_front u_front (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_mode, .req_trans_x, .req_trans_y, .req_trans_z,
      .req_rot_x, .req_rot_y, .req_rot_z, .req_button_word,
      .q_full, .q_push, .q_word(q_in)
   );

   sabed_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .push(q_push), .push_word(q_in), .full(q_full),
      .pop(q_pop), .not_empty(q_not_empty), .pop_word(q_out)
   );

   sabed_back u_back (
      .clock, .reset, .q_not_empty, .q_word(q_out), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_out_trans_x, .rsp_out_trans_y,
      .rsp_out_trans_z, .rsp_angle, .rsp_unit_x, .rsp_unit_y, .rsp_unit_z,
      .rsp_button_id, .rsp_modifier_set
   );

endmodule

>>> tb/testbench.sv
// testbench for the six-axis event decoder: directed and random words, scoreboard check
module testbench;
   import sabed_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] tx, ty, tz, rx, ry, rz;
      logic [31:0] buttons;
   } event_word_type;

   typedef struct {
      logic [1:0]  kind;
      logic [15:0] tx, ty, tz;
      logic [23:0] angle;
      logic [15:0] ux, uy, uz;
      logic [3:0]  id;
      logic [2:0]  mods;
   } decoded_word_type;

   localparam logic [1:0] MODE_OTHER_A = 2'd2;
   localparam logic [1:0] MODE_OTHER_B = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [15:0] req_trans_x = '0, req_trans_y = '0, req_trans_z = '0;
   logic [15:0] req_rot_x = '0, req_rot_y = '0, req_rot_z = '0;
   logic [31:0] req_button_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_out_trans_x, rsp_out_trans_y, rsp_out_trans_z;
   logic [23:0] rsp_angle;
   logic [15:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   logic [3:0]  rsp_button_id;
   logic [2:0]  rsp_modifier_set;

   six_axis_button_event_decoder dut (.*);

   initial forever #4 clock = ~clock;

   logic [31:0]      mask_reg;
   logic [31:0]      held_buttons;
   logic [2:0]       held_mods;
   decoded_word_type pending_q[$];
   int               errors = 0;
   int               words_sent = 0;
   int               results_seen = 0;
   int               idle_cycles = 0;

   function automatic logic [16:0] magnitude(logic [15:0] raw);
      return raw[15] ? 17'(18'h10000 - raw) : {1'b0, raw};
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] unit_part(logic [15:0] raw, logic [63:0] len);
      logic [63:0] q;
      q = (64'(magnitude(raw)) << 23) / len;
      if (raw[15]) return (q >= 32768) ? 16'h8000 : 16'(-q);
      return (q >= 32767) ? 16'h7fff : q[15:0];
   endfunction

   function automatic logic [3:0] id_of_change(logic [31:0] c);
      case (c)
         32'd4: return 4'd1;
         32'd16: return 4'd2;
         32'd32: return 4'd3;
         32'd256: return 4'd4;
         32'd67108864: return 4'd5;
         32'd4096: return 4'd6;
         32'd8192: return 4'd7;
         32'd16384: return 4'd8;
         32'd32768: return 4'd9;
         32'd4194304: return 4'd10;
         32'd16777216: return ID_SHIFT;
         32'd33554432: return ID_CTRL;
         32'd8388608: return ID_ALT;
         32'd1: return 4'd14;
         32'd2: return 4'd15;
         default: return ID_NONE;
      endcase
   endfunction

   task automatic predict_decode(event_word_type w);
      decoded_word_type d;
      logic [63:0] s, len;
      logic [31:0] masked, changed;
      logic [2:0]  mbit;
      logic        pressed;
      d = '{default: '0};
      if (w.mode == MODE_AXIS) begin
         s = 64'(magnitude(w.rx)) * magnitude(w.rx) + 64'(magnitude(w.ry)) * magnitude(w.ry)
            + 64'(magnitude(w.rz)) * magnitude(w.rz);
         len = root_floor(s << 16);
         d.kind = KIND_MOTION;
         d.tx = w.tx;
         d.ty = w.ty;
         d.tz = w.tz;
         d.angle = len[23:0];
         if (len == 0) begin
            d.uz = 16'h7fff;
         end else begin
            d.ux = unit_part(w.rx, len);
            d.uy = unit_part(w.ry, len);
            d.uz = unit_part(w.rz, len);
         end
         d.mods = held_mods;
         pending_q.push_back(d);
      end else if (w.mode == MODE_BUTTON) begin
         masked = w.buttons & mask_reg;
         changed = held_buttons ^ masked;
         pressed = (changed & masked) != 0;
         d.id = id_of_change(changed);
         held_buttons = masked;
         mbit = (d.id == ID_SHIFT) ? 3'd1 : (d.id == ID_CTRL) ? 3'd2 :
                (d.id == ID_ALT) ? 3'd4 : 3'd0;
         held_mods = pressed ? (held_mods | mbit) : (held_mods & ~mbit);
         d.kind = pressed ? KIND_PRESS : KIND_RELEASE;
         d.mods = held_mods;
         pending_q.push_back(d);
      end
   endtask

   task automatic send_word(event_word_type w);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= w.mode;
      req_trans_x <= w.tx;
      req_trans_y <= w.ty;
      req_trans_z <= w.tz;
      req_rot_x <= w.rx;
      req_rot_y <= w.ry;
      req_rot_z <= w.rz;
      req_button_word <= w.buttons;
      do @(posedge clock); while (!req_ready);
      predict_decode(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_mask(logic [31:0] m);
      req_valid <= 0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable <= 1;
      csr_write_data <= m;
      @(negedge clock);
      csr_write_enable <= 0;
      mask_reg = m;
   endtask

   function automatic event_word_type axis_word(logic [15:0] tx, ty, tz, rx, ry, rz);
      return '{MODE_AXIS, tx, ty, tz, rx, ry, rz, 32'h0};
   endfunction

   function automatic event_word_type button_word(logic [31:0] b);
      event_word_type w;
      w = '{default: '0};
      w.mode = MODE_BUTTON;
      w.buttons = b;
      w.tx = 16'($urandom);
      w.rx = 16'($urandom);
      return w;
   endfunction

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 6)) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_axis_directed();
      send_word(axis_word(16'h7fff, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0));
      send_word(axis_word(16'h8000, 16'h7fff, 16'hffff, 16'h8000, 16'h8000, 16'h8000));
      send_word(axis_word(16'h1, 16'h2, 16'h3, 16'h7fff, 16'h7fff, 16'h7fff));
      send_word(axis_word(16'h0, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0));
      send_word(axis_word(16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0));
      send_word(axis_word(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000));
      send_word(axis_word(16'h5555, 16'haaaa, 16'h1234, 16'h7fff, 16'h8000, 16'h1));
   endtask

   task automatic test_buttons_directed();
      write_mask(32'hffff_ffff);
      send_word(button_word(32'd16777216));
      send_word(button_word(32'd16777216 | 32'd33554432));
      send_word(button_word(32'd16777216 | 32'd33554432 | 32'd8388608));
      send_word(axis_word(16'h10, 16'h20, 16'h30, 16'h3, 16'h4, 16'h0));
      send_word(button_word(32'd16777216 | 32'd33554432 | 32'd8388608));
      send_word(button_word(32'd33554432 | 32'd8388608));
      send_word(button_word(32'd0));
      send_word(button_word(32'hffff_ffff));
      send_word(button_word(32'h8000_0000));
      send_word(button_word(32'd0));
      for (int k = 0; k < 2; k++) send_word('{2'(int'(MODE_OTHER_A) + k), 16'h1, 16'h1,
         16'h1, 16'h1, 16'h1, 16'h1, 32'hffff_ffff});
      write_mask(32'd0);
      send_word(button_word(32'hffff_ffff));
   endtask

   task automatic test_random_mix(int count, logic [31:0] m);
      event_word_type w;
      logic [31:0] prev;
      write_mask(m);
      prev = 0;
      repeat (count) begin
         w = axis_word(rand_axis(), rand_axis(), rand_axis(), rand_axis(), rand_axis(),
            rand_axis());
         case ($urandom_range(0, 9))
            0, 1, 2: ;
            3: w.mode = 2'($urandom_range(MODE_OTHER_A, MODE_OTHER_B));
            4: w = button_word($urandom);
            default: begin
               prev ^= 32'd1 << $urandom_range(0, 31);
               w = button_word(prev);
            end
         endcase
         send_word(w);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         decoded_word_type e;
         results_seen++;
         if (pending_q.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_kind); errors++; end
            if (rsp_out_trans_x !== e.tx) begin
               $error("out_trans_x exp %h got %h", e.tx, rsp_out_trans_x); errors++; end
            if (rsp_out_trans_y !== e.ty) begin
               $error("out_trans_y exp %h got %h", e.ty, rsp_out_trans_y); errors++; end
            if (rsp_out_trans_z !== e.tz) begin
               $error("out_trans_z exp %h got %h", e.tz, rsp_out_trans_z); errors++; end
            if (rsp_angle !== e.angle) begin
               $error("angle exp %h got %h", e.angle, rsp_angle); errors++; end
            if (rsp_unit_x !== e.ux) begin
               $error("unit_x exp %h got %h", e.ux, rsp_unit_x); errors++; end
            if (rsp_unit_y !== e.uy) begin
               $error("unit_y exp %h got %h", e.uy, rsp_unit_y); errors++; end
            if (rsp_unit_z !== e.uz) begin
               $error("unit_z exp %h got %h", e.uz, rsp_unit_z); errors++; end
            if (rsp_button_id !== e.id) begin
               $error("button_id exp %0d got %0d", e.id, rsp_button_id); errors++; end
            if (rsp_modifier_set !== e.mods) begin
               $error("modifier_set exp %0d got %0d", e.mods, rsp_modifier_set); errors++; end
         end
      end
   end

   // result side stalls, with runs of no stall
   initial begin
      int waits;
      forever begin
         @(negedge clock);
         waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (waits != 0) begin
            rsp_ready <= 0;
            repeat (waits) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      mask_reg = RESET_MASK;
      held_buttons = '0;
      held_mods = '0;
      repeat (10) @(negedge clock);
      reset <= 0;
      test_axis_directed();
      test_buttons_directed();
      test_random_mix(300, RESET_MASK);
      test_random_mix(300, 32'hffff_ffff);
      test_random_mix(300, 32'h03c0_f137);
      req_valid <= 0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d words, checked %0d results over four button masks",
         words_sent, results_seen);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
